>>> design/lru_key_value_cache_top_macros.svh
// Assertion helpers for the cache RTL.
`ifndef LRU_KEY_VALUE_CACHE_TOP_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_TOP_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define LKVC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lru cache: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define LKVC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lru cache: next-cycle check failed");

`endif

>>> design/lkvc_pkg.sv
package lkvc_pkg;

  localparam int DEFAULT_ENTRIES = 16;
  localparam int KEY_W = 32;
  localparam int VALUE_W = 32;
  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  localparam logic signed [VALUE_W-1:0] MISS_VALUE = -32'sd1;

  typedef struct packed {
    logic                      op;
    logic signed [KEY_W-1:0]   key;
    logic signed [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic                      hit;
    logic signed [VALUE_W-1:0] read_value;
    logic                      evicted;
    logic signed [KEY_W-1:0]   evicted_key;
  } rsp_t;

endpackage

>>> design/lru_key_value_cache_top.sv
// Fully associative key-value cache with least-recently-used replacement.
// Input channel (in_valid/in_ready): op (0 = get, 1 = put), lookup_key, put_value.
// Output channel (out_valid/out_ready): hit, read_value, evicted, evicted_key;
// exactly one result item per input item, in order.
// Config channel (cfg_valid/cfg_ready): cfg_data sets capacity_limit; it is always
// ready and should be written only while no item is in flight.
// An item accepted at a rising edge sits in the input register, and its result is
// loaded into the result register when the result register can advance.
// Throughput: one item per cycle while the receiver takes results. Lookup, recency
// update and insert for an item are resolved in the cycle it leaves the input
// register, so the next item already sees the updated entries.
// When the receiver stalls, the result register holds and the input register
// fills; in_ready drops only when both are occupied.
// Reset (synchronous, active high) clears all valid marks, ranks and the entry
// count, empties both registers and sets capacity_limit to 16. No clearing pass
// is needed; the cache is ready for items as soon as reset is released.
`include "lru_key_value_cache_top_macros.svh"

module lru_key_value_cache_top #(
  parameter int ENTRIES = lkvc_pkg::DEFAULT_ENTRIES,
  localparam int CNT_W = $clog2(ENTRIES + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                op,
  input  logic signed [lkvc_pkg::KEY_W-1:0]   lookup_key,
  input  logic signed [lkvc_pkg::VALUE_W-1:0] put_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                hit,
  output logic signed [lkvc_pkg::VALUE_W-1:0] read_value,
  output logic                                evicted,
  output logic signed [lkvc_pkg::KEY_W-1:0]   evicted_key,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lkvc_pkg::CAP_W-1:0]          cfg_data
);

  logic [lkvc_pkg::CAP_W-1:0] capacity_limit;
  logic                       q_valid;
  lkvc_pkg::req_t             q_req;
  lkvc_pkg::rsp_t             rsp;
  lkvc_pkg::rsp_t             rsp_q;
  logic                       advance;
  logic                       fire;
  logic [CNT_W-1:0]           entry_count;
  logic [ENTRIES-1:0]         entry_valid;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || out_ready;
  assign fire      = q_valid && advance;
  assign in_ready  = !q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= lkvc_pkg::CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_req.op    <= op;
      q_req.key   <= lookup_key;
      q_req.value <= put_value;
    end
  end

  lkvc_store #(
    .ENTRIES(ENTRIES)
  ) u_store (
    .clk           (clk),
    .rst           (rst),
    .capacity_limit(capacity_limit),
    .req           (q_req),
    .fire          (fire),
    .rsp           (rsp),
    .entry_count   (entry_count),
    .entry_valid   (entry_valid)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp_q <= rsp;
    end
  end

  assign hit         = rsp_q.hit;
  assign read_value  = rsp_q.read_value;
  assign evicted     = rsp_q.evicted;
  assign evicted_key = rsp_q.evicted_key;

  // The entry count always agrees with the number of valid marks.
  `LKVC_ASSERT_NOW(a_count_tracks_valid, 1'b1, int'(entry_count) == $countones(entry_valid))
  // A put that evicts reuses the slot it freed, so the count does not move.
  `LKVC_ASSERT_NEXT(a_evict_keeps_count, fire && rsp.evicted, $stable(entry_count))
  // A get never adds or removes entries.
  `LKVC_ASSERT_NEXT(a_get_keeps_count, fire && (q_req.op == lkvc_pkg::OP_GET), $stable(entry_count))
  // Only a put that missed can evict.
  `LKVC_ASSERT_NOW(a_evict_only_on_miss, out_valid && evicted, !hit)

endmodule

>>> design/lkvc_store.sv
module lkvc_store #(
  parameter int ENTRIES = lkvc_pkg::DEFAULT_ENTRIES,
  localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int CNT_W = $clog2(ENTRIES + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [lkvc_pkg::CAP_W-1:0]  capacity_limit,
  input  lkvc_pkg::req_t              req,
  input  logic                        fire,
  output lkvc_pkg::rsp_t              rsp,
  output logic [CNT_W-1:0]            entry_count,
  output logic [ENTRIES-1:0]          entry_valid
);

  localparam int CMP_W = (CNT_W > lkvc_pkg::CAP_W) ? CNT_W : lkvc_pkg::CAP_W;

  logic signed [lkvc_pkg::KEY_W-1:0]   entry_keys   [ENTRIES];
  logic signed [lkvc_pkg::VALUE_W-1:0] entry_values [ENTRIES];
  logic [RANK_W-1:0]                   recency_rank [ENTRIES];

  logic [RANK_W-1:0]                   recency_rank_next [ENTRIES];
  logic [ENTRIES-1:0]                  entry_valid_next;
  logic [CNT_W-1:0]                    entry_count_next;

  logic [ENTRIES-1:0]                  match;
  logic [ENTRIES-1:0]                  oldest;
  logic [ENTRIES-1:0]                  first_free;
  logic [ENTRIES-1:0]                  ins_sel;
  logic [ENTRIES-1:0]                  wr_en;
  logic                                hit;
  logic                                full;
  logic                                is_put;
  logic signed [lkvc_pkg::VALUE_W-1:0] hit_value;
  logic signed [lkvc_pkg::KEY_W-1:0]   oldest_key;
  logic [RANK_W-1:0]                   hit_rank;
  logic [RANK_W-1:0]                   last_rank;
  logic [CNT_W-1:0]                    count_minus_one;
  logic [CMP_W-1:0]                    cap_ext;
  logic [CMP_W-1:0]                    eff_cap;

  // Capacity zero acts as one; anything above the built depth saturates.
  always_comb begin
    cap_ext = CMP_W'(capacity_limit);
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign full            = CMP_W'(entry_count) >= eff_cap;
  assign count_minus_one = entry_count - CNT_W'(1);
  assign last_rank       = count_minus_one[RANK_W-1:0];
  assign is_put          = (req.op == lkvc_pkg::OP_PUT);

  // Keys and ranks are unique among valid entries, so the hit and oldest selects are at most one-hot.
  always_comb begin
    match      = '0;
    oldest     = '0;
    hit_value  = '0;
    hit_rank   = '0;
    oldest_key = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]  = entry_valid[i] && (entry_keys[i] == req.key);
      oldest[i] = entry_valid[i] && (recency_rank[i] == last_rank);
      if (match[i]) begin
        hit_value = hit_value | entry_values[i];
        hit_rank  = hit_rank | recency_rank[i];
      end
      if (oldest[i]) begin
        oldest_key = oldest_key | entry_keys[i];
      end
    end
  end

  // Lowest-numbered free slot.
  always_comb begin
    first_free = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!entry_valid[i]) begin
        first_free    = '0;
        first_free[i] = 1'b1;
      end
    end
  end

  assign hit     = |match;
  assign ins_sel = full ? oldest : first_free;
  assign wr_en   = (fire && is_put) ? (hit ? match : ins_sel) : '0;

  always_comb begin
    rsp.hit         = hit;
    rsp.evicted     = is_put && !hit && full;
    rsp.evicted_key = rsp.evicted ? oldest_key : '0;
    if (is_put) begin
      rsp.read_value = '0;
    end else if (hit) begin
      rsp.read_value = hit_value;
    end else begin
      rsp.read_value = lkvc_pkg::MISS_VALUE;
    end
  end

  always_comb begin
    entry_valid_next = entry_valid;
    entry_count_next = entry_count;
    for (int i = 0; i < ENTRIES; i++) begin
      recency_rank_next[i] = recency_rank[i];
    end
    if (fire) begin
      if (hit) begin
        // Touch: entries younger than the hit entry age by one.
        for (int i = 0; i < ENTRIES; i++) begin
          if (match[i]) begin
            recency_rank_next[i] = '0;
          end else if (entry_valid[i] && (recency_rank[i] < hit_rank)) begin
            recency_rank_next[i] = recency_rank[i] + RANK_W'(1);
          end
        end
      end else if (is_put) begin
        // Insert: the new entry is youngest and every other valid entry ages.
        for (int i = 0; i < ENTRIES; i++) begin
          if (ins_sel[i]) begin
            recency_rank_next[i] = '0;
            entry_valid_next[i]  = 1'b1;
          end else if (entry_valid[i]) begin
            recency_rank_next[i] = recency_rank[i] + RANK_W'(1);
          end
        end
        if (!full) begin
          entry_count_next = entry_count + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      entry_count <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        recency_rank[i] <= '0;
      end
    end else begin
      entry_valid <= entry_valid_next;
      entry_count <= entry_count_next;
      for (int i = 0; i < ENTRIES; i++) begin
        recency_rank[i] <= recency_rank_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (wr_en[i]) begin
        entry_keys[i]   <= req.key;
        entry_values[i] <= req.value;
      end
    end
  end

endmodule

>>> bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CACHE_LINES = lkvc_pkg::DEFAULT_ENTRIES;
  localparam int RESET_CYCLES = 11;
  localparam int IDLE_PCT = 15;
  localparam int HOLD_CYCLES = 200;
  localparam int STALL_LIMIT = 1000;
  localparam int PHASE_ITEMS = 175;
  localparam int PUT_PCT = 45;
  localparam int MAX_PRINTS = 20;
  localparam logic signed [lkvc_pkg::KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [lkvc_pkg::KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic                                op = lkvc_pkg::OP_GET;
  logic signed [lkvc_pkg::KEY_W-1:0]   lookup_key = '0;
  logic signed [lkvc_pkg::VALUE_W-1:0] put_value = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic                                hit;
  logic signed [lkvc_pkg::VALUE_W-1:0] read_value;
  logic                                evicted;
  logic signed [lkvc_pkg::KEY_W-1:0]   evicted_key;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [lkvc_pkg::CAP_W-1:0]          cfg_data = lkvc_pkg::CAP_RESET;

  lru_key_value_cache_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .lookup_key (lookup_key),
    .put_value  (put_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hit        (hit),
    .read_value (read_value),
    .evicted    (evicted),
    .evicted_key(evicted_key),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // Shadow copy of the cache contents, kept in step with accepted items.
  logic [lkvc_pkg::KEY_W-1:0]   line_key [CACHE_LINES];
  logic [lkvc_pkg::VALUE_W-1:0] line_val [CACHE_LINES];
  bit                           line_used [CACHE_LINES];
  int                           line_age [CACHE_LINES];
  int                           line_count;
  logic [lkvc_pkg::CAP_W-1:0]   cap_setting = lkvc_pkg::CAP_RESET;

  lkvc_pkg::req_t pending_req[$];
  lkvc_pkg::rsp_t expected_rsp[$];

  bit no_gaps = 1'b0;
  int hold_requests = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int errors = 0;
  int results_checked = 0;
  int hits_seen = 0;
  int evictions_seen = 0;
  int cfg_writes = 0;
  int quiet_cycles = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic void promote_line(int slot);
    for (int i = 0; i < CACHE_LINES; i++) begin
      if (line_used[i] && i != slot && line_age[i] < line_age[slot]) line_age[i]++;
    end
    line_age[slot] = 0;
  endfunction

  function automatic lkvc_pkg::rsp_t cache_access(lkvc_pkg::req_t r);
    lkvc_pkg::rsp_t res;
    int slot;
    int limit;
    int cap_int;
    int oldest;
    bit found;
    bit free_found;
    res = '0;
    slot = 0;
    found = 1'b0;
    for (int i = 0; i < CACHE_LINES; i++) begin
      if (!found && line_used[i] && line_key[i] == r.key) begin
        slot = i;
        found = 1'b1;
      end
    end
    res.hit = found;
    if (r.op == lkvc_pkg::OP_GET) begin
      if (found) begin
        res.read_value = line_val[slot];
        promote_line(slot);
      end else begin
        res.read_value = lkvc_pkg::MISS_VALUE;
      end
    end else if (found) begin
      line_val[slot] = r.value;
      promote_line(slot);
    end else begin
      cap_int = int'(cap_setting);
      limit = (cap_int == 0) ? 1 : (cap_int > CACHE_LINES ? CACHE_LINES : cap_int);
      if (line_count >= limit) begin
        // Ties go to the lowest slot, so only a strictly older entry replaces the pick.
        oldest = -1;
        for (int i = 0; i < CACHE_LINES; i++) begin
          if (line_used[i] && line_age[i] > oldest) begin
            oldest = line_age[i];
            slot = i;
          end
        end
        res.evicted = 1'b1;
        res.evicted_key = line_key[slot];
      end else begin
        free_found = 1'b0;
        for (int i = 0; i < CACHE_LINES; i++) begin
          if (!free_found && !line_used[i]) begin
            slot = i;
            free_found = 1'b1;
          end
        end
        line_count++;
      end
      for (int i = 0; i < CACHE_LINES; i++) begin
        if (line_used[i] && i != slot) line_age[i]++;
      end
      line_used[slot] = 1'b1;
      line_key[slot] = r.key;
      line_val[slot] = r.value;
      line_age[slot] = 0;
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (errors < MAX_PRINTS) begin
      $display("MISMATCH %s: got %h, expected %h", what, got, want);
    end
    errors++;
  endtask

  task automatic push_item(logic kind, logic [lkvc_pkg::KEY_W-1:0] key,
                           logic [lkvc_pkg::VALUE_W-1:0] value);
    lkvc_pkg::req_t r;
    r.op = kind;
    r.key = key;
    r.value = value;
    pending_req.push_back(r);
  endtask

  task automatic wait_drained();
    while (pending_req.size() != 0 || in_valid || expected_rsp.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(logic [lkvc_pkg::CAP_W-1:0] cap);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cap_setting = cap;
    cfg_writes++;
  endtask

  always @(posedge clk) begin : drive_inputs
    lkvc_pkg::req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      line_count = 0;
      for (int i = 0; i < CACHE_LINES; i++) begin
        line_used[i] = 1'b0;
        line_age[i] = 0;
      end
    end else begin
      if (in_valid && in_ready) begin
        nxt.op = op;
        nxt.key = lookup_key;
        nxt.value = put_value;
        expected_rsp.push_back(cache_access(nxt));
      end
      if (!in_valid || in_ready) begin
        if (pending_req.size() != 0 && (no_gaps || $urandom_range(99) >= IDLE_PCT)) begin
          nxt = pending_req.pop_front();
          in_valid <= 1'b1;
          op <= nxt.op;
          lookup_key <= nxt.key;
          put_value <= nxt.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_seen != hold_requests) begin
      hold_seen <= hold_requests;
      hold_left <= HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : check_results
    lkvc_pkg::rsp_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_rsp.size() == 0) begin
        report_mismatch("result item with nothing pending", read_value, '0);
      end else begin
        want = expected_rsp.pop_front();
        if (hit !== want.hit) report_mismatch("hit", 32'(hit), 32'(want.hit));
        if (read_value !== want.read_value) begin
          report_mismatch("read_value", read_value, want.read_value);
        end
        if (evicted !== want.evicted) begin
          report_mismatch("evicted", 32'(evicted), 32'(want.evicted));
        end
        if (evicted_key !== want.evicted_key) begin
          report_mismatch("evicted_key", evicted_key, want.evicted_key);
        end
        results_checked++;
        if (want.hit) hits_seen++;
        if (want.evicted) evictions_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("lru_key_value_cache_top test failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int caps [10];
    logic [lkvc_pkg::KEY_W-1:0] key_pool [40];
    int pool_n;
    logic [lkvc_pkg::KEY_W-1:0] key;
    caps = '{16, 3, 1, 8, 16, 5, 2, 12, 15, 4};
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Default capacity: put four keys including the extremes, then hits, a miss and an update.
    push_item(lkvc_pkg::OP_PUT, KEY_MIN, KEY_MAX);
    push_item(lkvc_pkg::OP_PUT, KEY_MAX, KEY_MIN);
    push_item(lkvc_pkg::OP_PUT, '0, '0);
    push_item(lkvc_pkg::OP_PUT, '1, '1);
    push_item(lkvc_pkg::OP_GET, KEY_MIN, '0);
    push_item(lkvc_pkg::OP_GET, KEY_MAX, '1);
    push_item(lkvc_pkg::OP_GET, 32'd1, '0);
    push_item(lkvc_pkg::OP_PUT, '0, 32'd12345);
    push_item(lkvc_pkg::OP_GET, '0, '0);
    push_item(lkvc_pkg::OP_GET, '1, '0);
    wait_drained();

    // Capacity two is below the four held entries, so every put miss evicts.
    write_capacity(5'd2);
    push_item(lkvc_pkg::OP_PUT, 32'd5, 32'd50);
    push_item(lkvc_pkg::OP_PUT, 32'd6, 32'd60);
    push_item(lkvc_pkg::OP_GET, 32'd5, '0);
    push_item(lkvc_pkg::OP_PUT, 32'd7, 32'd70);
    push_item(lkvc_pkg::OP_GET, 32'd6, '0);
    push_item(lkvc_pkg::OP_GET, 32'd5, '0);
    push_item(lkvc_pkg::OP_PUT, 32'd8, 32'd80);
    wait_drained();

    write_capacity(5'd1);
    push_item(lkvc_pkg::OP_PUT, 32'd9, 32'd90);
    push_item(lkvc_pkg::OP_GET, 32'd9, '0);
    push_item(lkvc_pkg::OP_PUT, 32'd10, 32'd100);
    push_item(lkvc_pkg::OP_GET, 32'd9, '0);
    wait_drained();

    // Random phases: keys mostly come from a pool a little larger than the
    // capacity, so hits, updates and evictions all happen often.
    for (int p = 0; p < 10; p++) begin
      write_capacity(caps[p][lkvc_pkg::CAP_W-1:0]);
      no_gaps = (p == 5);
      pool_n = caps[p] + int'($urandom_range(caps[p], 1));
      for (int i = 0; i < pool_n; i++) key_pool[i] = $urandom;
      key_pool[$urandom_range(pool_n - 1)] = KEY_MIN;
      key_pool[$urandom_range(pool_n - 1)] = KEY_MAX;
      if (p == 2) hold_requests++;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(pool_n - 1)] : $urandom;
        push_item(($urandom_range(99) < PUT_PCT) ? lkvc_pkg::OP_PUT : lkvc_pkg::OP_GET,
                  key, $urandom);
      end
      wait_drained();
    end
    no_gaps = 1'b0;

    repeat (4) @(posedge clk);
    if (expected_rsp.size() != 0) begin
      report_mismatch("result items never delivered", '0, expected_rsp.size());
    end
    $display("Checked %0d result items across %0d capacity writes, from 1 to 16 entries.",
             results_checked, cfg_writes);
    $display("Saw %0d hits and %0d evictions, including a long output stall.",
             hits_seen, evictions_seen);
    if (errors == 0) begin
      $display("lru_key_value_cache_top test passed");
    end else begin
      $display("lru_key_value_cache_top test failed");
    end
    $finish;
  end

endmodule
